// ===== rtl/les_pkg.sv =====
// shared types and constants for the look elevator request scheduler
package les_pkg;

  localparam int FLOORS      = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int FLOOR_W     = 4;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int REM_W       = $clog2(2 * QUEUE_DEPTH + 1);

  localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(FLOORS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN_UP,
    ST_SCAN_DN
  } les_state_e;

  // access to the per-floor count store
  typedef struct packed {
    logic               wr_en;
    logic               set_dn;
    logic [FLOOR_W-1:0] addr;
    logic [CNT_W-1:0]   wdata;
  } les_store_req_t;

  // car floor update from the sequencer
  typedef struct packed {
    logic               load;
    logic [FLOOR_W-1:0] floor;
  } les_car_upd_t;

endpackage

// ===== rtl/les_count_store.sv =====
// per-floor pending request counts for the up and down sets
module les_count_store
  import les_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  les_store_req_t req_i,
  output logic [CNT_W-1:0] rd_data_o
);

  logic [CNT_W-1:0] up_cnt_q [FLOORS];
  logic [CNT_W-1:0] dn_cnt_q [FLOORS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FLOORS; i++) begin
        up_cnt_q[i] <= '0;
        dn_cnt_q[i] <= '0;
      end
    end else if (req_i.wr_en) begin
      if (req_i.set_dn) begin
        dn_cnt_q[req_i.addr] <= req_i.wdata;
      end else begin
        up_cnt_q[req_i.addr] <= req_i.wdata;
      end
    end
  end

  assign rd_data_o = req_i.set_dn ? dn_cnt_q[req_i.addr] : up_cnt_q[req_i.addr];

endmodule

// ===== rtl/les_seq.sv =====
// sequencer: request insertion and floor-by-floor serving sweep with one step unit
module les_seq
  import les_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  input  logic [FLOOR_W-1:0] in_floor_i,
  input  logic [FLOOR_W-1:0] car_floor_i,
  output les_car_upd_t       car_upd_o,
  output les_store_req_t     store_req_o,
  input  logic [CNT_W-1:0]   cnt_rd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FLOOR_W-1:0] out_floor_o,
  output logic               out_down_o,
  output logic               out_last_o
);

  les_state_e         state_q, state_d;
  logic [FLOOR_W-1:0] idx_q, idx_d;
  logic               set_dn_q, set_dn_d;
  logic [CNT_W-1:0]   up_total_q, up_total_d;
  logic [CNT_W-1:0]   dn_total_q, dn_total_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic               m_valid_q, m_valid_d;
  logic [FLOOR_W-1:0] m_floor_q, m_floor_d;
  logic               m_down_q, m_down_d;
  logic               m_last_q, m_last_d;

  logic               accept;
  logic               out_free;
  logic               cnt_nz;
  logic               step_inc;
  logic [CNT_W-1:0]   step_res;
  logic [REM_W-1:0]   pend_sum;
  logic               in_range;
  logic               set_full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !m_valid_q || out_ready_i;
  assign cnt_nz     = (cnt_rd_i != '0);
  assign pend_sum   = REM_W'(up_total_q) + REM_W'(dn_total_q);
  assign in_range   = (32'(in_floor_i) < FLOORS);
  assign set_full   = set_dn_q ? (32'(dn_total_q) >= QUEUE_DEPTH)
                               : (32'(up_total_q) >= QUEUE_DEPTH);

  // shared count step: increment on insert, decrement on serve
  assign step_inc = (state_q == ST_ADD);
  assign step_res = step_inc ? (cnt_rd_i + CNT_W'(1)) : (cnt_rd_i - CNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i) begin
            state_d = (pend_sum != '0) ? ST_SCAN_UP : ST_IDLE;
          end else if (in_range) begin
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        state_d = ST_IDLE;
      end
      ST_SCAN_UP: begin
        if (rem_q == '0) begin
          state_d = ST_IDLE;
        end else if (!cnt_nz && idx_q == TOP_FLOOR) begin
          state_d = ST_SCAN_DN;
        end
      end
      ST_SCAN_DN: begin
        if (rem_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d       = idx_q;
    set_dn_d    = set_dn_q;
    up_total_d  = up_total_q;
    dn_total_d  = dn_total_q;
    rem_d       = rem_q;
    m_valid_d   = m_valid_q && !out_ready_i;
    m_floor_d   = m_floor_q;
    m_down_d    = m_down_q;
    m_last_d    = m_last_q;
    car_upd_o   = '0;
    store_req_o.wr_en  = 1'b0;
    store_req_o.set_dn = set_dn_q;
    store_req_o.addr   = idx_q;
    store_req_o.wdata  = step_res;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i) begin
            idx_d      = '0;
            rem_d      = pend_sum;
            up_total_d = '0;
            dn_total_d = '0;
          end else begin
            idx_d    = in_floor_i;
            set_dn_d = !(in_floor_i > car_floor_i);
          end
        end
      end
      ST_ADD: begin
        if (!set_full) begin
          store_req_o.wr_en = 1'b1;
          if (set_dn_q) begin
            dn_total_d = dn_total_q + CNT_W'(1);
          end else begin
            up_total_d = up_total_q + CNT_W'(1);
          end
        end
      end
      ST_SCAN_UP, ST_SCAN_DN: begin
        store_req_o.set_dn = (state_q == ST_SCAN_DN);
        if (rem_q != '0) begin
          if (cnt_nz) begin
            if (out_free) begin
              store_req_o.wr_en = 1'b1;
              rem_d           = rem_q - REM_W'(1);
              m_valid_d       = 1'b1;
              m_floor_d       = idx_q;
              m_down_d        = (state_q == ST_SCAN_DN);
              m_last_d        = (rem_q == REM_W'(1));
              car_upd_o.load  = 1'b1;
              car_upd_o.floor = idx_q;
            end
          end else if (state_q == ST_SCAN_UP) begin
            idx_d = (idx_q == TOP_FLOOR) ? TOP_FLOOR : idx_q + FLOOR_W'(1);
          end else begin
            idx_d = idx_q - FLOOR_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      up_total_q <= '0;
      dn_total_q <= '0;
      rem_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      up_total_q <= up_total_d;
      dn_total_q <= dn_total_d;
      rem_q      <= rem_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    set_dn_q  <= set_dn_d;
    m_floor_q <= m_floor_d;
    m_down_q  <= m_down_d;
    m_last_q  <= m_last_d;
  end

  assign out_valid_o = m_valid_q;
  assign out_floor_o = m_floor_q;
  assign out_down_o  = m_down_q;
  assign out_last_o  = m_last_q;

endmodule

// ===== rtl/look_elevator_request_scheduler_core.sv =====
// look elevator request scheduler: top level with car floor register and config port
// an add request is taken in the transfer and then updates the floor count in the add state
// a serve with requests pending sweeps up from floor 0 to the top floor, then back down,
// emitting one result per served request through one count step unit;
// a serve with nothing pending goes straight back to idle
// output stalls hold the sweep on the current floor; one item is in work at a time
// reset clears all pending counts and totals, empties the output and puts the car at floor 0
module look_elevator_request_scheduler_core
  import les_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,    // start_floor
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] floor, [7:4] zero
  input  logic       s_axis_tuser,   // op
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] served_floor, [7:4] zero
  output logic       m_axis_tuser,   // moving_down
  output logic       m_axis_tlast
);

  logic [FLOOR_W-1:0] car_q, car_d;
  les_car_upd_t       car_upd;
  les_store_req_t     store_req;
  logic [CNT_W-1:0]   cnt_rd;
  logic [FLOOR_W-1:0] out_floor;

  // config write places the car, clamped to the top floor
  always_comb begin
    car_d = car_q;
    if (cfg_we_i) begin
      car_d = (32'(cfg_wdata_i) >= FLOORS) ? TOP_FLOOR : FLOOR_W'(cfg_wdata_i);
    end else if (car_upd.load) begin
      car_d = car_upd.floor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q <= '0;
    end else begin
      car_q <= car_d;
    end
  end

  les_count_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (cnt_rd)
  );

  les_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_floor_i  (s_axis_tdata[FLOOR_W-1:0]),
    .car_floor_i (car_q),
    .car_upd_o   (car_upd),
    .store_req_o (store_req),
    .cnt_rd_i    (cnt_rd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_floor_o (out_floor),
    .out_down_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_floor};

endmodule
